>>> src/ccss_pkg.sv
package ccss_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_WEIGHT     = 3'd0;
    localparam logic [2:0] REG_RES_A      = 3'd1;
    localparam logic [2:0] REG_RES_B      = 3'd2;
    localparam logic [2:0] REG_RES_C      = 3'd3;
    localparam logic [2:0] REG_RES_D      = 3'd4;
    localparam logic [2:0] REG_CELL_CONST = 3'd5;
    localparam logic [2:0] REG_SPAN_LOW   = 3'd6;
    localparam logic [2:0] REG_SPAN_HIGH  = 3'd7;

    // reset values
    localparam logic [16:0] WEIGHT_DEFAULT    = 17'd19661;
    localparam logic [16:0] WEIGHT_ONE        = 17'd65536;
    localparam logic [29:0] RES_DEFAULT       = 30'd1000000;
    localparam logic [24:0] CELL_DEFAULT      = 25'd65536;
    localparam logic [26:0] SPAN_LOW_DEFAULT  = 27'd0;
    localparam logic [26:0] SPAN_HIGH_DEFAULT = 27'd1000000;

    // arithmetic constants
    localparam logic signed [23:0] OFFSET_UV   = 24'sd20000;
    localparam logic signed [16:0] TEMP_OFFSET = 17'sd5000;
    localparam logic [52:0] SCALE_NUM   = 53'd6000000000000000;
    localparam logic [31:0] SCALE_LO    = SCALE_NUM[31:0];
    localparam logic [31:0] SCALE_HI    = {11'd0, SCALE_NUM[52:32]};
    localparam logic [46:0] MAG_MAX     = {47{1'b1}};
    localparam logic [31:0] LOOP_GAIN   = 32'd16000;
    localparam logic [14:0] LOOP_ZERO   = 15'd4000;
    localparam logic [14:0] LOOP_FULL   = 15'd24000;
    localparam logic [14:0] LOOP_UP_MAX = 15'd20000;
    localparam logic [5:0]  DIV1_STEPS  = 6'd46;
    localparam logic [5:0]  DIV2_STEPS  = 6'd14;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_DCHK,
        ST_DRUN,
        ST_XSET,
        ST_DIFF,
        ST_SMUL,
        ST_SFIN,
        ST_SCALE,
        ST_GOUT,
        ST_LSUB,
        ST_LMUL,
        ST_FIN,
        ST_OUT
    } state_t;

endpackage

>>> src/conductivity_compensate_smooth_scale_top.sv
// conductivity front end: per beat computes (|a|*6e15)/(R*|c-20000|*|2t+5000|), the
// temperature compensated conductance in 0.01 uS, signs it, smooths it exponentially
// (first sample taken as is), scales it by the Q9.16 cell constant with a clamp at
// zero and maps it onto a 4..20 mA loop current saturated to 0..24000 uA. all products
// run through one 32x32 multiplier with a registered output, both divisions through one
// radix-2 restoring divider (one quotient bit a cycle). one beat is in flight at a time:
// s_tready is high only while the block is idle. a beat runs the multiplier passes, the
// conductance quotient division and the loop current division before the next beat can
// be accepted; a saturating quotient ends its division early and the first sample skips
// smoothing. a zero resistor, a cell voltage of exactly 20000 uV or a temperature of
// -25.00 degC gives a result with only math_error set, with no multiplier or divider
// pass, and leaves the smoothing state alone. configuration must be written by the user
// through cfg_wr_en/cfg_index/cfg_wdata only while idle; the block does not enforce it.
module conductivity_compensate_smooth_scale_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [29:0] cfg_wdata,
    // sample input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // current_sense_uv[22:0], cell_voltage_uv[45:23],
                                   // temperature_centi[60:46], zero fill
    input  logic [1:0]  s_tuser,   // range_index[1:0]
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // conductance_centi[31:0], loop_current_ua[46:32],
                                   // out_of_span[47], math_error[48], zero fill
);

    ccss_pkg::state_t state_reg, state_next;

    // configuration registers
    logic [16:0] weight_reg;
    logic [29:0] res_a_reg, res_b_reg, res_c_reg, res_d_reg;
    logic [24:0] cell_const_reg;
    logic [26:0] span_low_reg, span_high_reg;

    // smoothing state
    logic signed [47:0] s_reg;
    logic               first_reg;

    // sequencing
    logic [2:0] mop_reg;      // multiplier pass counter within a phase
    logic [5:0] cnt_reg;      // divider bit counter
    logic       div_sel_reg;  // 0: conductance quotient, 1: loop current quotient

    // per-beat operands
    logic [22:0] a_mag_reg;
    logic [22:0] dc_mag_reg;
    logic [15:0] dt_mag_reg;
    logic [29:0] r_reg;
    logic        neg_reg;
    logic [16:0] w_reg;

    // shared multiplier and accumulators
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_reg;
    logic [52:0] p1_reg;
    logic [74:0] num_reg;
    logic [71:0] acc_reg;

    // shared divider
    logic [68:0] den_reg;
    logic [68:0] rem_reg;
    logic [46:0] sh_reg;
    logic [46:0] q_reg;
    logic        dsat_reg;
    logic [69:0] cmp_in;
    logic [70:0] trial;
    logic        ge;

    // value chain
    logic signed [47:0] x_reg;
    logic [48:0]        dmag_reg;
    logic               dneg_reg;
    logic [31:0]        g_reg;
    logic [31:0]        lmag_reg;
    logic               qneg_reg;

    // output register
    logic [31:0] cond_out_reg;
    logic [14:0] loop_out_reg;
    logic        oos_out_reg;
    logic        err_out_reg;

    // input field decode
    logic signed [22:0] in_a, in_c;
    logic signed [14:0] in_t;
    logic [1:0]         in_idx;
    logic signed [23:0] dc_w;
    logic signed [16:0] dt_w;
    logic [29:0]        r_sel;
    logic               in_err;
    logic               accept_in;

    assign in_a   = s_tdata[22:0];
    assign in_c   = s_tdata[45:23];
    assign in_t   = s_tdata[60:46];
    assign in_idx = s_tuser;

    assign dc_w = {in_c[22], in_c} - ccss_pkg::OFFSET_UV;
    assign dt_w = {in_t[14], in_t, 1'b0} + ccss_pkg::TEMP_OFFSET;

    always_comb begin
        case (in_idx)
            2'd0:    r_sel = res_a_reg;
            2'd1:    r_sel = res_b_reg;
            2'd2:    r_sel = res_c_reg;
            default: r_sel = res_d_reg;
        endcase
    end

    assign in_err    = (r_sel == '0) || (dc_w == '0) || (dt_w == '0);
    assign accept_in = s_tvalid && s_tready;

    // divider compare: check pass looks at the remainder as loaded, run passes shift in
    assign cmp_in = (state_reg == ccss_pkg::ST_DCHK) ? {1'b0, rem_reg}
                                                    : {rem_reg, sh_reg[46]};
    assign trial  = {1'b0, cmp_in} - {2'b00, den_reg};
    assign ge     = ~trial[70];

    // signed conductance from the first quotient
    logic [46:0]        mag_w;
    logic signed [47:0] xval_w;
    assign mag_w  = dsat_reg ? ccss_pkg::MAG_MAX : q_reg;
    assign xval_w = neg_reg ? -$signed({1'b0, mag_w}) : $signed({1'b0, mag_w});

    // smoothing difference
    logic signed [48:0] diff_w;
    assign diff_w = {x_reg[47], x_reg} - {s_reg[47], s_reg};

    // rounded smoothing update: s + floor((+-|d|*w + 32768) / 65536)
    logic signed [72:0] tval_w, rnd_w, snew_w;
    assign tval_w = dneg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
    assign rnd_w  = tval_w + 73'sd32768;
    assign snew_w = $signed({{25{s_reg[47]}}, s_reg}) + (rnd_w >>> 16);

    // cell constant scaling with clamp at zero and 32 bit saturation
    logic [31:0] g_w;
    always_comb begin
        if (x_reg[47] || (x_reg == '0)) begin
            g_w = '0;
        end else if (|acc_reg[71:48]) begin
            g_w = '1;
        end else begin
            g_w = acc_reg[47:16];
        end
    end

    // span with equal-span fallback
    logic [26:0]        lo_e, hi_e;
    logic signed [33:0] lnum_w, lneg_val_w;
    logic signed [27:0] span_w, span_neg_w;
    assign lo_e       = (span_low_reg == span_high_reg) ? 27'd0 : span_low_reg;
    assign hi_e       = (span_low_reg == span_high_reg) ? 27'd1000000 : span_high_reg;
    assign lnum_w     = $signed({2'b00, g_reg}) - $signed({7'd0, lo_e});
    assign lneg_val_w = -lnum_w;
    assign span_w     = $signed({1'b0, hi_e}) - $signed({1'b0, lo_e});
    assign span_neg_w = -span_w;

    // loop current from the second quotient
    logic [14:0] lq_w;
    logic [14:0] loop_w;
    logic        oos_w;
    assign lq_w = q_reg[14:0];
    always_comb begin
        if (qneg_reg) begin
            if (dsat_reg || (lq_w > ccss_pkg::LOOP_ZERO)) begin
                loop_w = '0;
                oos_w  = 1'b1;
            end else begin
                loop_w = ccss_pkg::LOOP_ZERO - lq_w;
                oos_w  = 1'b0;
            end
        end else begin
            if (dsat_reg || (lq_w > ccss_pkg::LOOP_UP_MAX)) begin
                loop_w = ccss_pkg::LOOP_FULL;
                oos_w  = 1'b1;
            end else begin
                loop_w = ccss_pkg::LOOP_ZERO + lq_w;
                oos_w  = 1'b0;
            end
        end
    end

    // multiplier operand select per phase and pass
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ccss_pkg::ST_PROD: begin
                case (mop_reg)
                    3'd0: begin
                        mul_a = 32'(r_reg);
                        mul_b = 32'(dc_mag_reg);
                    end
                    3'd1: begin
                        mul_a = 32'(a_mag_reg);
                        mul_b = ccss_pkg::SCALE_LO;
                    end
                    3'd2: begin
                        mul_a = 32'(a_mag_reg);
                        mul_b = ccss_pkg::SCALE_HI;
                    end
                    3'd3: begin
                        mul_a = p1_reg[31:0];
                        mul_b = 32'(dt_mag_reg);
                    end
                    3'd4: begin
                        mul_a = 32'(p1_reg[52:32]);
                        mul_b = 32'(dt_mag_reg);
                    end
                    default: ;
                endcase
            end
            ccss_pkg::ST_SMUL: begin
                mul_b = 32'(w_reg);
                case (mop_reg)
                    3'd0:    mul_a = dmag_reg[31:0];
                    default: mul_a = 32'(dmag_reg[48:32]);
                endcase
            end
            ccss_pkg::ST_SCALE: begin
                mul_b = 32'(cell_const_reg);
                case (mop_reg)
                    3'd0:    mul_a = x_reg[31:0];
                    default: mul_a = 32'(x_reg[46:32]);
                endcase
            end
            ccss_pkg::ST_LMUL: begin
                mul_a = lmag_reg;
                mul_b = ccss_pkg::LOOP_GAIN;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ccss_pkg::ST_IDLE: begin
                if (accept_in) begin
                    state_next = in_err ? ccss_pkg::ST_OUT : ccss_pkg::ST_PROD;
                end
            end
            ccss_pkg::ST_PROD: begin
                if (mop_reg == 3'd5) state_next = ccss_pkg::ST_DCHK;
            end
            ccss_pkg::ST_DCHK: begin
                if (ge) begin
                    state_next = div_sel_reg ? ccss_pkg::ST_FIN : ccss_pkg::ST_XSET;
                end else begin
                    state_next = ccss_pkg::ST_DRUN;
                end
            end
            ccss_pkg::ST_DRUN: begin
                if (cnt_reg == '0) begin
                    state_next = div_sel_reg ? ccss_pkg::ST_FIN : ccss_pkg::ST_XSET;
                end
            end
            ccss_pkg::ST_XSET: begin
                state_next = first_reg ? ccss_pkg::ST_SCALE : ccss_pkg::ST_DIFF;
            end
            ccss_pkg::ST_DIFF:  state_next = ccss_pkg::ST_SMUL;
            ccss_pkg::ST_SMUL: begin
                if (mop_reg == 3'd2) state_next = ccss_pkg::ST_SFIN;
            end
            ccss_pkg::ST_SFIN:  state_next = ccss_pkg::ST_SCALE;
            ccss_pkg::ST_SCALE: begin
                if (mop_reg == 3'd2) state_next = ccss_pkg::ST_GOUT;
            end
            ccss_pkg::ST_GOUT:  state_next = ccss_pkg::ST_LSUB;
            ccss_pkg::ST_LSUB:  state_next = ccss_pkg::ST_LMUL;
            ccss_pkg::ST_LMUL: begin
                if (mop_reg == 3'd1) state_next = ccss_pkg::ST_DCHK;
            end
            ccss_pkg::ST_FIN:   state_next = ccss_pkg::ST_OUT;
            ccss_pkg::ST_OUT: begin
                if (m_tready) state_next = ccss_pkg::ST_IDLE;
            end
            default:            state_next = ccss_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_tready = (state_reg == ccss_pkg::ST_IDLE);
        m_tvalid = (state_reg == ccss_pkg::ST_OUT);
        m_tdata  = {7'd0, err_out_reg, oos_out_reg, loop_out_reg, cond_out_reg};
    end

    // control state, configuration and smoothing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ccss_pkg::ST_IDLE;
            mop_reg        <= '0;
            weight_reg     <= ccss_pkg::WEIGHT_DEFAULT;
            res_a_reg      <= ccss_pkg::RES_DEFAULT;
            res_b_reg      <= ccss_pkg::RES_DEFAULT;
            res_c_reg      <= ccss_pkg::RES_DEFAULT;
            res_d_reg      <= ccss_pkg::RES_DEFAULT;
            cell_const_reg <= ccss_pkg::CELL_DEFAULT;
            span_low_reg   <= ccss_pkg::SPAN_LOW_DEFAULT;
            span_high_reg  <= ccss_pkg::SPAN_HIGH_DEFAULT;
            s_reg          <= '0;
            first_reg      <= 1'b1;
        end else begin
            state_reg <= state_next;
            // pass counter restarts on every phase change
            mop_reg   <= (state_next != state_reg) ? 3'd0 : mop_reg + 3'd1;

            if (cfg_wr_en) begin
                unique case (cfg_index)
                    ccss_pkg::REG_WEIGHT:     weight_reg     <= cfg_wdata[16:0];
                    ccss_pkg::REG_RES_A:      res_a_reg      <= cfg_wdata;
                    ccss_pkg::REG_RES_B:      res_b_reg      <= cfg_wdata;
                    ccss_pkg::REG_RES_C:      res_c_reg      <= cfg_wdata;
                    ccss_pkg::REG_RES_D:      res_d_reg      <= cfg_wdata;
                    ccss_pkg::REG_CELL_CONST: cell_const_reg <= cfg_wdata[24:0];
                    ccss_pkg::REG_SPAN_LOW:   span_low_reg   <= cfg_wdata[26:0];
                    ccss_pkg::REG_SPAN_HIGH:  span_high_reg  <= cfg_wdata[26:0];
                    default: ;
                endcase
            end

            if (state_reg == ccss_pkg::ST_XSET && first_reg) begin
                s_reg     <= xval_w;
                first_reg <= 1'b0;
            end else if (state_reg == ccss_pkg::ST_SFIN) begin
                s_reg <= snew_w[47:0];
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;

        case (state_reg)
            ccss_pkg::ST_IDLE: begin
                if (accept_in) begin
                    a_mag_reg  <= in_a[22] ? 23'(-{in_a[22], in_a}) : 23'(in_a);
                    dc_mag_reg <= dc_w[23] ? 23'(-dc_w) : dc_w[22:0];
                    dt_mag_reg <= dt_w[16] ? 16'(-dt_w) : dt_w[15:0];
                    r_reg      <= r_sel;
                    neg_reg    <= in_a[22] ^ dc_w[23] ^ dt_w[16];
                    w_reg      <= ((weight_reg == '0) || (weight_reg > ccss_pkg::WEIGHT_ONE))
                                  ? ccss_pkg::WEIGHT_DEFAULT : weight_reg;
                    // error result is ready right away
                    cond_out_reg <= '0;
                    loop_out_reg <= '0;
                    oos_out_reg  <= 1'b0;
                    err_out_reg  <= in_err;
                end
            end
            ccss_pkg::ST_PROD: begin
                // each pass consumes the registered product of the previous pass
                case (mop_reg)
                    3'd1: p1_reg  <= prod_reg[52:0];
                    3'd2: num_reg <= 75'(prod_reg);
                    3'd3: num_reg <= num_reg + (75'(prod_reg) << 32);
                    3'd4: den_reg <= 69'(prod_reg);
                    3'd5: begin
                        den_reg     <= den_reg + (69'(prod_reg) << 32);
                        rem_reg     <= 69'(num_reg[74:47]);
                        sh_reg      <= num_reg[46:0];
                        q_reg       <= '0;
                        div_sel_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
            ccss_pkg::ST_DCHK: begin
                // quotient does not fit the result width when the top part already covers it
                dsat_reg <= ge;
                cnt_reg  <= div_sel_reg ? ccss_pkg::DIV2_STEPS : ccss_pkg::DIV1_STEPS;
            end
            ccss_pkg::ST_DRUN: begin
                rem_reg <= ge ? trial[68:0] : cmp_in[68:0];
                q_reg   <= {q_reg[45:0], ge};
                sh_reg  <= {sh_reg[45:0], 1'b0};
                cnt_reg <= cnt_reg - 6'd1;
            end
            ccss_pkg::ST_XSET: begin
                x_reg <= xval_w;
            end
            ccss_pkg::ST_DIFF: begin
                dneg_reg <= diff_w[48];
                dmag_reg <= diff_w[48] ? 49'(-diff_w) : 49'(diff_w);
            end
            ccss_pkg::ST_SMUL, ccss_pkg::ST_SCALE: begin
                case (mop_reg)
                    3'd1:    acc_reg <= 72'(prod_reg);
                    3'd2:    acc_reg <= acc_reg + (72'(prod_reg) << 32);
                    default: ;
                endcase
            end
            ccss_pkg::ST_SFIN: begin
                x_reg <= snew_w[47:0];
            end
            ccss_pkg::ST_GOUT: begin
                g_reg <= g_w;
            end
            ccss_pkg::ST_LSUB: begin
                lmag_reg <= lnum_w[33] ? lneg_val_w[31:0] : lnum_w[31:0];
                den_reg  <= span_w[27] ? 69'(span_neg_w[26:0]) : 69'(span_w[26:0]);
                qneg_reg <= lnum_w[33] ^ span_w[27];
            end
            ccss_pkg::ST_LMUL: begin
                if (mop_reg == 3'd1) begin
                    rem_reg     <= 69'(prod_reg[45:15]);
                    sh_reg      <= {prod_reg[14:0], 32'd0};
                    q_reg       <= '0;
                    div_sel_reg <= 1'b1;
                end
            end
            ccss_pkg::ST_FIN: begin
                cond_out_reg <= g_reg;
                loop_out_reg <= loop_w;
                oos_out_reg  <= oos_w;
                err_out_reg  <= 1'b0;
            end
            default: ;
        endcase
    end

endmodule
